FILE: hdl/g711enc_pkg.sv
// Shared types and constants for the PCM16 to G.711 encoder.
// No dependencies; compiled before the interfaces and the top level.
`default_nettype none

package g711enc_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] sample_type;
   typedef logic [2:0]  seg_type;
   typedef logic [3:0]  mant_type;

   // Configuration register map, one 32-bit register every four bytes.
   localparam int unsigned CSR_ADDR_W = 3;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   typedef enum logic {
      CSR_LAW_SELECT = 1'b0,
      CSR_BYTE_ORDER = 1'b1
   } csr_index_type;

   typedef enum logic {
      LAW_A  = 1'b0,
      LAW_MU = 1'b1
   } law_type;

   typedef enum logic {
      ORDER_BIG    = 1'b0,
      ORDER_LITTLE = 1'b1
   } order_type;

   localparam sample_type ALAW_CLIP    = 16'd32767;
   localparam sample_type ULAW_CLIP    = 16'd32635;
   localparam sample_type ULAW_BIAS    = 16'h0084;
   localparam byte_type   ALAW_XOR     = 8'hD5;
   localparam byte_type   ULAW_ZERO    = 8'h02;
   localparam byte_type   SIGN_BIT     = 8'h80;

endpackage : g711enc_pkg

`default_nettype wire

FILE: hdl/g711enc_if.sv
// Valid/ready stream interfaces for the encoder's byte input and code output.
// Depends on g711enc_pkg for the payload types.
`default_nettype none

interface g711enc_req_if;
   import g711enc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface : g711enc_req_if

interface g711enc_rsp_if;
   import g711enc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type code_byte;
   logic     last_code;

   modport source (output valid, output code_byte, output last_code, input ready);
   modport sink   (input valid, input code_byte, input last_code, output ready);
endinterface : g711enc_rsp_if

`default_nettype wire

FILE: hdl/pcm16_to_g711_encoder_top.sv
// Top level of the PCM16 to G.711 (A-law / mu-law) encoder.
// Depends on g711enc_pkg and the stream interfaces in g711enc_if.sv.
//
// Usage:
//   The req_stream channel carries one byte of a 16-bit PCM stream per word,
//   with frame_end marking the last byte of a frame. Consecutive bytes are
//   paired into one sample in the order set by the byte_order register; a
//   first byte that carries frame_end is dropped and pairing starts afresh.
//   Every completed pair yields one word on rsp_stream: the 8-bit G.711 code
//   chosen by law_select, with last_code copying the second byte's frame_end.
//   The first byte of a pair produces no output word.
//
//   The code of a pair reaches rsp_stream through two registers, the sample
//   register and then the code register.
//   Throughput: one byte per cycle while rsp_stream is not stalled; the
//   companding logic (negate, clip, bias add, segment priority encode,
//   mantissa shift) fits between the sample register and the code register.
//   When the receiver stalls, the code register holds its word and the
//   sample register fills; req_stream.ready then drops until space opens.
//   Reset (synchronous, active high) empties both pipeline stages, forgets
//   any held first byte and returns both registers to A-law, big endian.
//   The csr_ APB port always completes in its access cycle (pready high).
`default_nettype none

module pcm16_to_g711_encoder_top (
   input  wire                        clock,
   input  wire                        reset,
   g711enc_req_if.sink                req_stream,
   g711enc_rsp_if.source              rsp_stream,
   input  wire                        csr_psel,
   input  wire                        csr_penable,
   input  wire                        csr_pwrite,
   input  wire g711enc_pkg::csr_addr_type csr_paddr,
   input  wire [31:0]                 csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import g711enc_pkg::*;

   // Configuration registers.
   law_type    law_ff, law_in;
   order_type  order_ff, order_in;
   csr_index_type csr_index;
   logic       csr_write;

   // Byte pairing state.
   byte_type   held_ff, held_in;
   logic       have_first_ff, have_first_in;

   // Sample register (first pipeline stage).
   logic       s1_valid_ff, s1_valid_in;
   sample_type s1_sample_ff, s1_sample_in;
   logic       s1_last_ff, s1_last_in;
   law_type    s1_law_ff, s1_law_in;

   // Code register (output stage).
   logic       out_valid_ff, out_valid_in;
   byte_type   out_code_ff, out_code_in;
   logic       out_last_ff, out_last_in;

   logic       out_ready;
   logic       s1_ready;
   logic       req_fire;
   logic       pair_done;

   // Companding datapath.
   logic       sign;
   sample_type mag_abs;
   sample_type mag_a;
   sample_type mag_u_clip;
   sample_type mag_u;
   seg_type    seg_a;
   seg_type    seg_u;
   mant_type   mant_a;
   mant_type   mant_u;
   byte_type   code_a;
   byte_type   code_u;
   byte_type   code_u_raw;

   // Segment: 7 when bit 14 is set, down to 1 for bit 8, else 0.
   function automatic seg_type seg_of(input sample_type mag);
      seg_type seg;
      unique casez (mag[14:8])
         7'b1??????: seg = 3'd7;
         7'b01?????: seg = 3'd6;
         7'b001????: seg = 3'd5;
         7'b0001???: seg = 3'd4;
         7'b00001??: seg = 3'd3;
         7'b000001?: seg = 3'd2;
         7'b0000001: seg = 3'd1;
         default:    seg = 3'd0;
      endcase
      return seg;
   endfunction

   // Four mantissa bits starting at bit seg+3.
   function automatic mant_type mant_at(input sample_type mag, input seg_type seg);
      sample_type shifted;
      shifted = mag >> ({1'b0, seg} + 4'd3);
      return shifted[3:0];
   endfunction

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_comb begin
      law_in   = law_ff;
      order_in = order_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LAW_SELECT: law_in   = law_type'(csr_pwdata[0]);
            CSR_BYTE_ORDER: order_in = order_type'(csr_pwdata[0]);
            default:        law_in   = law_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_LAW_SELECT: csr_prdata = {31'd0, law_ff};
         CSR_BYTE_ORDER: csr_prdata = {31'd0, order_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake and byte pairing
   // ------------------------------------------------------------------
   assign out_ready        = !out_valid_ff || rsp_stream.ready;
   assign s1_ready         = !s1_valid_ff || out_ready;
   assign req_stream.ready = s1_ready;
   assign req_fire         = req_stream.valid && s1_ready;
   assign pair_done        = req_fire && have_first_ff;

   always_comb begin
      held_in       = held_ff;
      have_first_in = have_first_ff;
      if (req_fire) begin
         if (have_first_ff) begin
            have_first_in = 1'b0;
         end else if (!req_stream.frame_end) begin
            // A lone byte that ends a frame is simply dropped.
            held_in       = req_stream.data_byte;
            have_first_in = 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff && !out_ready;
      s1_sample_in = s1_sample_ff;
      s1_last_in   = s1_last_ff;
      s1_law_in    = s1_law_ff;
      if (pair_done) begin
         s1_valid_in  = 1'b1;
         s1_sample_in = (order_ff == ORDER_LITTLE) ? {req_stream.data_byte, held_ff}
                                                   : {held_ff, req_stream.data_byte};
         s1_last_in   = req_stream.frame_end;
         s1_law_in    = law_ff;
      end
   end

   // ------------------------------------------------------------------
   // Companding: sign/magnitude, clip, segment, mantissa
   // ------------------------------------------------------------------
   assign sign    = s1_sample_ff[15];
   // Negation wraps, so the most negative sample stays 0x8000 and clips below.
   assign mag_abs = sign ? (~s1_sample_ff + 16'd1) : s1_sample_ff;

   assign mag_a  = (mag_abs > ALAW_CLIP) ? ALAW_CLIP : mag_abs;
   assign seg_a  = seg_of(mag_a);
   assign mant_a = (seg_a < 3'd2) ? mag_a[7:4] : mant_at(mag_a, seg_a);
   assign code_a = {sign, seg_a, mant_a} ^ ALAW_XOR;

   assign mag_u_clip = (mag_abs > ULAW_CLIP) ? ULAW_CLIP : mag_abs;
   assign mag_u      = mag_u_clip + ULAW_BIAS;
   assign seg_u      = seg_of(mag_u);
   assign mant_u     = mant_at(mag_u, seg_u);
   assign code_u_raw = ~{sign, seg_u, mant_u};
   // An all-zero mu-law code is replaced to avoid long runs of zeros on the line.
   assign code_u     = (code_u_raw == 8'd0) ? ULAW_ZERO : code_u_raw;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;
      if (out_ready) begin
         out_valid_in = s1_valid_ff;
         out_code_in  = (s1_law_ff == LAW_MU) ? code_u : code_a;
         out_last_in  = s1_last_ff;
      end
   end

   assign rsp_stream.valid     = out_valid_ff;
   assign rsp_stream.code_byte = out_code_ff;
   assign rsp_stream.last_code = out_last_ff;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         law_ff        <= LAW_A;
         order_ff      <= ORDER_BIG;
         have_first_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         law_ff        <= law_in;
         order_ff      <= order_in;
         have_first_ff <= have_first_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff      <= held_in;
      s1_sample_ff <= s1_sample_in;
      s1_last_ff   <= s1_last_in;
      s1_law_ff    <= s1_law_in;
      out_code_ff  <= out_code_in;
      out_last_ff  <= out_last_in;
   end

endmodule : pcm16_to_g711_encoder_top

`default_nettype wire

FILE: tb/pcm16_to_g711_encoder_top_tb.sv
// Self-checking testbench for the PCM16 to G.711 encoder top level.
// Depends on g711enc_pkg, the stream interfaces in g711enc_if.sv and the RTL top.
// A scoreboard class predicts every code word; plain tasks drive bytes and registers.
`timescale 1ns / 100ps

module pcm16_to_g711_encoder_top_tb;
   import g711enc_pkg::*;

   // Run-length and timing knobs. The code of a pair passes the encoder's sample
   // and code registers, so a short settle covers the pipeline.
   localparam int unsigned PART_BYTES  = 470;
   localparam int unsigned SETTLE_GAP  = 4;
   localparam int unsigned LONG_STALL  = 300;
   localparam int unsigned CYCLE_LIMIT = 200000;

   // Scoreboard: mirrors the byte pairing and the two registers, computes the
   // companded code of every completed pair and checks the outgoing words
   // against those codes in order.
   class g711_scoreboard;
      law_type    cur_law    = LAW_A;
      order_type  cur_order  = ORDER_BIG;
      byte_type   held       = '0;
      bit         have_first = 1'b0;
      logic [8:0] codes_due[$];
      int         mismatches = 0;

      function void set_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_LAW_SELECT: cur_law   = law_type'(value[0]);
            CSR_BYTE_ORDER: cur_order = order_type'(value[0]);
            default: ;
         endcase
      endfunction

      function byte_type compand(sample_type pcm);
         logic       sgn;
         sample_type mag;
         seg_type    seg;
         mant_type   mant;
         byte_type   code;
         sgn = pcm[15];
         mag = sgn ? ~pcm + 16'd1 : pcm;
         if (cur_law == LAW_MU) begin
            if (mag > ULAW_CLIP) mag = ULAW_CLIP;
            mag = mag + ULAW_BIAS;
         end else if (mag > ALAW_CLIP) begin
            mag = ALAW_CLIP;
         end
         // Highest set bit among 14..8 picks the segment; none set means 0.
         seg = '0;
         for (int b = 8; b <= 14; b++)
            if (mag[b]) seg = seg_type'(b - 7);
         if (cur_law == LAW_A && seg < 2) mant = mag[7:4];
         else mant = mant_type'(mag >> (seg + 3));
         code = {sgn, seg, mant};
         if (cur_law == LAW_A) begin
            code = code ^ ALAW_XOR;
         end else begin
            code = ~code;
            if (code == 8'h00) code = ULAW_ZERO;
         end
         return code;
      endfunction

      // Called for every byte the encoder accepts.
      function void note_byte(byte_type data, logic last);
         sample_type pcm;
         if (!have_first) begin
            // A first byte that ends the frame has no partner and is dropped.
            if (!last) begin
               held       = data;
               have_first = 1'b1;
            end
            return;
         end
         pcm        = (cur_order == ORDER_LITTLE) ? {data, held} : {held, data};
         have_first = 1'b0;
         codes_due.push_back({compand(pcm), last});
      endfunction

      // Called for every code word the encoder hands over.
      function void check_code(byte_type code, logic last);
         logic [8:0] want;
         if (codes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: unexpected code %h last %b", code, last);
            return;
         end
         want = codes_due.pop_front();
         if (want[8:1] !== code || want[0] !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected code %h last %b, got code %h last %b",
                        want[8:1], want[0], code, last);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   csr_addr_type csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   g711enc_req_if req_if ();
   g711enc_rsp_if rsp_if ();

   g711_scoreboard board = new;

   // Idle rates in percent for the byte sender and the code receiver, plus a
   // request counter for long receiver stalls. The main sequence owns all of
   // these; the receiver process only reads them.
   int          src_idle_pct  = 33;
   int          sink_idle_pct = 60;
   int unsigned stall_requests = 0;
   int unsigned sent = 0;
   int unsigned cycles = 0;

   pcm16_to_g711_encoder_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_stream  (req_if),
      .rsp_stream  (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: a correct run finishes far below this many cycles.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Code receiver. Words are checked at the edge where valid and ready are
   // both high; ready for the next cycle is then drawn at random, or held low
   // for a long stretch when the main sequence asks for one. The stall is
   // counted here so the sender keeps offering bytes meanwhile and the
   // encoder's pipeline fills and pushes back on the byte stream.
   int unsigned stall_served = 0;
   int unsigned stall_left   = 0;
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_code(rsp_if.code_byte, rsp_if.last_code);
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_requests != stall_served) begin
         stall_served <= stall_requests;
         stall_left   <= LONG_STALL;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // Offers one byte, after a random number of idle cycles, and returns at the
   // edge where the encoder took it. Valid stays high on return so that the
   // next byte can follow back to back.
   task automatic send_byte(byte_type data, logic last);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= data;
      req_if.frame_end <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      board.note_byte(data, last);
      sent++;
   endtask

   task automatic send_pair(byte_type first, byte_type second, logic last);
      send_byte(first, 1'b0);
      send_byte(second, last);
   endtask

   // Stops offering bytes and waits until every predicted code has arrived,
   // then a few more cycles so the pipeline is surely empty.
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (board.codes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   // APB write: setup cycle, access cycle, done at the edge with pready high.
   // psel then drops and the task waits out an idle edge, so back-to-back writes never collide on psel.
   task automatic csr_write(csr_index_type idx, logic value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= csr_addr_type'({idx, 2'b00});
      csr_pwdata  <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      board.set_reg(idx, {31'd0, value});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Samples spread over all segments, with the clip points and the most
   // negative value showing up often.
   function automatic sample_type random_sample();
      sample_type mag;
      case ($urandom_range(15))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return sample_type'(ULAW_CLIP + $urandom_range(2) - 1);
         default: begin
            mag = sample_type'($urandom) >> $urandom_range(15);
            return $urandom_range(1) ? ~mag + 16'd1 : mag;
         end
      endcase
   endfunction

   // A well-formed frame of one to eight samples in the current byte order,
   // sometimes followed by an odd byte that ends a frame on its own (which the
   // encoder drops) or by a stray word that shifts the pairing.
   task automatic send_frame();
      int unsigned count;
      sample_type  pcm;
      count = $urandom_range(8, 1);
      for (int k = 0; k < count; k++) begin
         pcm = random_sample();
         if (board.cur_order == ORDER_LITTLE)
            send_pair(pcm[7:0], pcm[15:8], k == count - 1);
         else
            send_pair(pcm[15:8], pcm[7:0], k == count - 1);
      end
      if ($urandom_range(99) < 15) send_byte(byte_type'($urandom), 1'b1);
      if ($urandom_range(99) < 8)  send_byte(byte_type'($urandom), 1'($urandom_range(1)));
   endtask

   initial begin
      int unsigned goal;
      bit          paused;
      paused           = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.frame_end = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset settings, A-law and big endian: zero, the
      // largest positive sample, the most negative sample, minus one, the
      // segment one boundary with a frame end, and a lone frame-ending byte.
      send_pair(8'h00, 8'h00, 1'b0);
      send_pair(8'h7F, 8'hFF, 1'b0);
      send_pair(8'h80, 8'h00, 1'b0);
      send_pair(8'hFF, 8'hFF, 1'b0);
      send_pair(8'h01, 8'h00, 1'b1);
      send_byte(8'hA5, 1'b1);

      // Mu-law: right at the clip level, one above it, the most negative
      // sample (whose code comes out as zero and is replaced) and zero.
      settle_block();
      csr_write(CSR_LAW_SELECT, LAW_MU);
      send_pair(8'h7F, 8'h7B, 1'b0);
      send_pair(8'h7F, 8'h7C, 1'b0);
      send_pair(8'h80, 8'h00, 1'b0);
      send_pair(8'h00, 8'h00, 1'b1);

      // Both registers change while a first byte is held; the pair completes
      // under the new law and byte order.
      send_byte(8'h12, 1'b0);
      settle_block();
      csr_write(CSR_LAW_SELECT, LAW_A);
      csr_write(CSR_BYTE_ORDER, ORDER_LITTLE);
      send_byte(8'h34, 1'b1);
      send_pair(8'hFF, 8'h7F, 1'b0);
      send_byte(8'h5A, 1'b1);

      // Random frames in four parts, each under its own register settings.
      // The sender idles less than the receiver in part one, the other way
      // round in part two, and neither idles afterwards. Part three opens
      // with a long receiver stall; part four pauses halfway until every
      // code has come back.
      for (int part = 0; part < 4; part++) begin
         settle_block();
         case (part)
            0: begin
               csr_write(CSR_LAW_SELECT, LAW_MU);
               csr_write(CSR_BYTE_ORDER, ORDER_BIG);
               src_idle_pct  = 33;
               sink_idle_pct = 60;
            end
            1: begin
               csr_write(CSR_LAW_SELECT, LAW_A);
               csr_write(CSR_BYTE_ORDER, ORDER_LITTLE);
               src_idle_pct  = 60;
               sink_idle_pct = 33;
            end
            2: begin
               csr_write(CSR_LAW_SELECT, LAW_MU);
               csr_write(CSR_BYTE_ORDER, ORDER_LITTLE);
               src_idle_pct   = 0;
               sink_idle_pct  = 0;
               stall_requests <= stall_requests + 1;
            end
            default: begin
               csr_write(CSR_LAW_SELECT, LAW_A);
               csr_write(CSR_BYTE_ORDER, ORDER_BIG);
               src_idle_pct  = 0;
               sink_idle_pct = 0;
            end
         endcase
         goal = sent + PART_BYTES;
         while (sent < goal) begin
            if (part == 3 && !paused && sent + PART_BYTES / 2 >= goal) begin
               settle_block();
               paused = 1'b1;
            end
            send_frame();
         end
      end

      settle_block();
      if (board.mismatches == 0 && board.codes_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule : pcm16_to_g711_encoder_top_tb
